// ===== src/lkpmd_pkg.sv =====
package lkpmd_pkg;

    // Frame geometry
    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int ADDR_W      = COL_W + ROW_W;
    localparam int FRAME_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 9;

    // Arithmetic widths
    localparam int DIFF_W = PIX_W + 1;      // signed pixel difference
    localparam int ACC_W  = 22;             // sum of nine squared differences
    localparam int PROD_W = 2 * ACC_W;      // product of two sums
    localparam int SUM_W  = PROD_W + 1;     // sum of two products

    // Commands
    typedef enum logic [1:0] {
        CMD_WRITE_REF = 2'd0,
        CMD_WRITE_CUR = 2'd1,
        CMD_TEST      = 2'd2,
        CMD_NONE      = 2'd3
    } command_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_COLUMNS = 1'b0,
        REG_ROWS    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        command_t          command;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [PIX_W-1:0]  pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0] point_column;
        logic [ROW_W-1:0] point_row;
    } out_item_t;

endpackage

// ===== src/lk_point_motion_detector.sv =====
// Moving-point detector by 3x3 Lucas-Kanade flow over two stored frames.
//
// Input channel (in_valid/in_ready/in_data): each item is a command. Pixel
// writes to the reference or current frame produce no result. A point test
// reads a 4x4 patch of the current frame and the 3x3 window of the reference
// frame, one pixel per cycle from the two frame RAMs, accumulates the normal
// equations, then forms the products, the determinant and the sign decision.
// No new command is taken until the test is through, since each frame RAM has
// a single read port and the accumulator is shared.
// A test point on the border is rejected in its accepting cycle.
// Output channel (out_valid/out_ready/out_data): one item for each point
// judged moving. The result sits in an output register; new commands are
// taken while it waits. If a second result is ready before the first is
// taken, the block holds it until the output register frees.
// Config port (cfg_we/cfg_index/cfg_data): frame columns and rows; the user
// writes them only while idle, unchecked by the block. Reset sets both to 256
// and clears all control state; frame contents are undefined until written.
module lk_point_motion_detector (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  lkpmd_pkg::in_item_t                   in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output lkpmd_pkg::out_item_t                  out_data,
    input  logic                                  cfg_we,
    input  lkpmd_pkg::cfg_index_t                 cfg_index,
    input  logic [lkpmd_pkg::CFG_W-1:0]           cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ACC,
        ST_MUL,
        ST_DET,
        ST_DECIDE
    } state_t;

    localparam int PATCH = 16;

    state_t state_reg;
    logic [4:0] cnt_reg;
    logic [lkpmd_pkg::COL_W-1:0] qx_reg;
    logic [lkpmd_pkg::ROW_W-1:0] qy_reg;
    logic [lkpmd_pkg::CFG_W-1:0] cols_reg, rows_reg;
    logic out_valid_reg;
    lkpmd_pkg::out_item_t out_data_reg;

    logic [lkpmd_pkg::PIX_W-1:0] cur_sr [PATCH];
    logic [lkpmd_pkg::PIX_W-1:0] ref_sr [PATCH];

    logic signed [lkpmd_pkg::ACC_W-1:0] axx_reg, axy_reg, ayy_reg, bx_reg, by_reg;
    logic signed [lkpmd_pkg::PROD_W-1:0] p_det1_reg, p_det2_reg;
    logic signed [lkpmd_pkg::PROD_W-1:0] p_ayy_bx_reg, p_axy_by_reg, p_axx_by_reg;
    logic signed [lkpmd_pkg::PROD_W-1:0] p_axy_bx_reg, p_axx_bx_reg, p_ayy_by_reg;
    logic signed [lkpmd_pkg::SUM_W-1:0] det_reg;
    logic a_zero_reg;

    // Frame RAMs
    logic in_fire;
    logic ref_we, cur_we;
    logic [lkpmd_pkg::ADDR_W-1:0] waddr, raddr;
    logic [lkpmd_pkg::PIX_W-1:0] ref_rdata, cur_rdata;
    logic [lkpmd_pkg::ROW_W-1:0] rd_row;
    logic [lkpmd_pkg::COL_W-1:0] rd_col;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign ref_we   = in_fire && (in_data.command == lkpmd_pkg::CMD_WRITE_REF);
    assign cur_we   = in_fire && (in_data.command == lkpmd_pkg::CMD_WRITE_CUR);
    assign waddr    = {in_data.row, in_data.column};

    // Patch address: row y-1+k/4, column x-1+k%4
    assign rd_row = qy_reg - lkpmd_pkg::ROW_W'(1)
                    + lkpmd_pkg::ROW_W'(cnt_reg[3:2]);
    assign rd_col = qx_reg - lkpmd_pkg::COL_W'(1)
                    + lkpmd_pkg::COL_W'(cnt_reg[1:0]);
    assign raddr  = {rd_row, rd_col};

    lkpmd_ram #(
        .WIDTH (lkpmd_pkg::PIX_W),
        .DEPTH (lkpmd_pkg::FRAME_DEPTH)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (waddr),
        .wdata (in_data.pixel_value),
        .raddr (raddr),
        .rdata (ref_rdata)
    );

    lkpmd_ram #(
        .WIDTH (lkpmd_pkg::PIX_W),
        .DEPTH (lkpmd_pkg::FRAME_DEPTH)
    ) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (waddr),
        .wdata (in_data.pixel_value),
        .raddr (raddr),
        .rdata (cur_rdata)
    );

    // Border check on the query point, with sizes clamped to the frame store
    logic [lkpmd_pkg::CFG_W-1:0] cols_use, rows_use;
    logic [lkpmd_pkg::CFG_W:0] x_plus2, y_plus2;
    logic in_bounds;

    assign cols_use = (cols_reg > lkpmd_pkg::CFG_W'(lkpmd_pkg::MAX_COLUMNS))
                      ? lkpmd_pkg::CFG_W'(lkpmd_pkg::MAX_COLUMNS) : cols_reg;
    assign rows_use = (rows_reg > lkpmd_pkg::CFG_W'(lkpmd_pkg::MAX_ROWS))
                      ? lkpmd_pkg::CFG_W'(lkpmd_pkg::MAX_ROWS) : rows_reg;
    assign x_plus2  = (lkpmd_pkg::CFG_W + 1)'(in_data.column) + 10'd2;
    assign y_plus2  = (lkpmd_pkg::CFG_W + 1)'(in_data.row) + 10'd2;
    assign in_bounds = (in_data.column > lkpmd_pkg::COL_W'(1))
                    && (in_data.row > lkpmd_pkg::ROW_W'(1))
                    && (x_plus2 < {1'b0, cols_use})
                    && (y_plus2 < {1'b0, rows_use});

    // Window taps: pixel, right neighbor, lower neighbor, reference
    logic signed [lkpmd_pkg::DIFF_W-1:0] gx, gy, dt;
    logic signed [2*lkpmd_pkg::DIFF_W-1:0] m_xx, m_xy, m_yy, m_bx, m_by;
    logic acc_en;

    assign gx = $signed({1'b0, cur_sr[1]}) - $signed({1'b0, cur_sr[0]});
    assign gy = $signed({1'b0, cur_sr[4]}) - $signed({1'b0, cur_sr[0]});
    assign dt = $signed({1'b0, ref_sr[0]}) - $signed({1'b0, cur_sr[0]});
    assign m_xx = gx * gx;
    assign m_xy = gx * gy;
    assign m_yy = gy * gy;
    assign m_bx = gx * dt;
    assign m_by = gy * dt;
    // Last patch column only serves as a right neighbor
    assign acc_en = (cnt_reg[1:0] != 2'd3);

    // Sign decision
    logic signed [lkpmd_pkg::SUM_W-1:0] u_val, v_val;
    logic moving, out_free, result_load;

    always_comb
    begin
        if (det_reg > 0)
        begin
            u_val = lkpmd_pkg::SUM_W'(p_ayy_bx_reg) - lkpmd_pkg::SUM_W'(p_axy_by_reg);
            v_val = lkpmd_pkg::SUM_W'(p_axx_by_reg) - lkpmd_pkg::SUM_W'(p_axy_bx_reg);
        end
        else if (!a_zero_reg)
        begin
            u_val = lkpmd_pkg::SUM_W'(p_axx_bx_reg) + lkpmd_pkg::SUM_W'(p_axy_by_reg);
            v_val = lkpmd_pkg::SUM_W'(p_axy_bx_reg) + lkpmd_pkg::SUM_W'(p_ayy_by_reg);
        end
        else
        begin
            u_val = '0;
            v_val = '0;
        end
    end

    assign moving      = (u_val > 0) || (v_val > 0);
    assign out_free    = !out_valid_reg || out_ready;
    assign result_load = (state_reg == ST_DECIDE) && moving && out_free;

    // Patch shift lines: load shifts RAM data in, accumulation walks the taps
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_LOAD && cnt_reg != 5'd0) || state_reg == ST_ACC)
        begin
            for (int i = 0; i < PATCH - 1; i++)
            begin
                cur_sr[i] <= cur_sr[i+1];
                ref_sr[i] <= ref_sr[i+1];
            end
            cur_sr[PATCH-1] <= cur_rdata;
            ref_sr[PATCH-1] <= ref_rdata;
        end
    end

    // Arithmetic datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_LOAD:
            begin
                axx_reg <= '0;
                axy_reg <= '0;
                ayy_reg <= '0;
                bx_reg  <= '0;
                by_reg  <= '0;
            end
            ST_ACC:
            begin
                if (acc_en)
                begin
                    axx_reg <= axx_reg + lkpmd_pkg::ACC_W'(m_xx);
                    axy_reg <= axy_reg + lkpmd_pkg::ACC_W'(m_xy);
                    ayy_reg <= ayy_reg + lkpmd_pkg::ACC_W'(m_yy);
                    bx_reg  <= bx_reg + lkpmd_pkg::ACC_W'(m_bx);
                    by_reg  <= by_reg + lkpmd_pkg::ACC_W'(m_by);
                end
            end
            ST_MUL:
            begin
                p_det1_reg   <= axx_reg * ayy_reg;
                p_det2_reg   <= axy_reg * axy_reg;
                p_ayy_bx_reg <= ayy_reg * bx_reg;
                p_axy_by_reg <= axy_reg * by_reg;
                p_axx_by_reg <= axx_reg * by_reg;
                p_axy_bx_reg <= axy_reg * bx_reg;
                p_axx_bx_reg <= axx_reg * bx_reg;
                p_ayy_by_reg <= ayy_reg * by_reg;
                a_zero_reg   <= (axx_reg == '0) && (axy_reg == '0) && (ayy_reg == '0);
            end
            ST_DET:
            begin
                det_reg <= lkpmd_pkg::SUM_W'(p_det1_reg) - lkpmd_pkg::SUM_W'(p_det2_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Control and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            qx_reg        <= '0;
            qy_reg        <= '0;
            cols_reg      <= lkpmd_pkg::CFG_W'(256);
            rows_reg      <= lkpmd_pkg::CFG_W'(256);
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lkpmd_pkg::REG_COLUMNS: cols_reg <= cfg_data;
                    lkpmd_pkg::REG_ROWS:    rows_reg <= cfg_data;
                endcase
            end

            // Taken result clears unless a new one loads in the same cycle
            if (out_valid_reg && out_ready && !result_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && in_data.command == lkpmd_pkg::CMD_TEST && in_bounds)
                    begin
                        qx_reg    <= in_data.column;
                        qy_reg    <= in_data.row;
                        cnt_reg   <= '0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    if (cnt_reg == 5'(PATCH))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_ACC;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_ACC:
                begin
                    if (cnt_reg == 5'd11)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_DET;
                end
                ST_DET:
                begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    if (!moving)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (result_load)
                    begin
                        out_valid_reg             <= 1'b1;
                        out_data_reg.point_column <= qx_reg;
                        out_data_reg.point_row    <= qy_reg;
                        state_reg                 <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== src/lkpmd_ram.sv =====
module lkpmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/lkpmd_checker.sv =====
module lkpmd_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input lkpmd_pkg::in_item_t   in_data,
    input logic                  out_valid,
    input logic                  out_ready,
    input lkpmd_pkg::out_item_t  out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // No result while reset is held
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

    // Pixel writes and unused commands never stall the next item
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.command != lkpmd_pkg::CMD_TEST |=> in_ready)
        else $error("block busy after a pixel write");

    // A test point makes the block busy or lets it return at once, never a result in its place
    a_test_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared one cycle after an item");

endmodule

bind lk_point_motion_detector lkpmd_checker u_lkpmd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== bench/tb_lk_point_motion_detector.sv =====
module tb_lk_point_motion_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import lkpmd_pkg::*;

    localparam int REGION    = 8;      // side of the fully written patch at the origin
    localparam int HOLD_OFF  = 3000;   // long receiver stall
    localparam int WDOG_MAX  = 20000;  // cycles without any transfer
    localparam int DRAIN_CYC = 80;     // well above a worst-case test latency

    typedef enum int {FILL_RANDOM, FILL_FLAT, FILL_RAMP} fill_mode_t;

    typedef struct {
        command_t cmd;
        int       col;
        int       row;
        int       pix;
        int       hit;   // -1: not typed, 0/1: typed result count
    } step_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_we = 1'b0;
    cfg_index_t cfg_index = REG_COLUMNS;
    logic [CFG_W-1:0] cfg_data = '0;

    // Predictor state
    logic [PIX_W-1:0] ref_pix [FRAME_DEPTH];
    logic [PIX_W-1:0] cur_pix [FRAME_DEPTH];
    bit               ref_set [FRAME_DEPTH];
    bit               cur_set [FRAME_DEPTH];
    int               cols_reg = 256;
    int               rows_reg = 256;
    out_item_t        moving_q[$];

    int  errors = 0;
    int  n_items = 0;
    int  n_tests = 0;
    int  n_moving = 0;
    int  n_taken = 0;
    int  idle_cycles = 0;
    bit  hold_req = 1'b0;
    bit  steady = 1'b0;

    step_t dir_tab[15] = '{
        '{CMD_TEST,      0,   0,   0,   0},
        '{CMD_TEST,      255, 255, 255, 0},
        '{CMD_TEST,      1,   128, 0,   0},
        '{CMD_TEST,      128, 1,   0,   0},
        '{CMD_TEST,      254, 128, 0,   0},
        '{CMD_TEST,      128, 254, 0,   0},
        '{CMD_NONE,      77,  88,  99,  0},
        '{CMD_NONE,      255, 255, 255, 0},
        '{CMD_WRITE_REF, 255, 255, 255, -1},
        '{CMD_WRITE_CUR, 255, 255, 0,   -1},
        '{CMD_WRITE_REF, 0,   0,   0,   -1},
        '{CMD_WRITE_CUR, 0,   0,   255, -1},
        '{CMD_WRITE_CUR, 170, 85,  170, -1},
        '{CMD_TEST,      255, 2,   0,   0},
        '{CMD_TEST,      2,   255, 0,   0}
    };

    lk_point_motion_detector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Gap length: mostly none or short, now and then long
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic int pix_addr(int x, int y);
        return y * MAX_COLUMNS + x;
    endfunction

    function automatic bit on_border(int x, int y);
        int c;
        int r;
        c = (cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : cols_reg;
        r = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        return (x <= 1 || x >= c - 2 || y <= 1 || y >= r - 2);
    endfunction

    // True when every pixel that a test at (x,y) uses has been written
    function automatic bit window_written(int x, int y);
        int dx;
        int dy;
        for (dy = -1; dy <= 1; dy++)
            for (dx = -1; dx <= 1; dx++)
                if (!ref_set[pix_addr(x + dx, y + dy)] || !cur_set[pix_addr(x + dx, y + dy)]
                    || !cur_set[pix_addr(x + dx + 1, y + dy)]
                    || !cur_set[pix_addr(x + dx, y + dy + 1)])
                    return 1'b0;
        return 1'b1;
    endfunction

    // Sign of the least-squares flow, exact in integers
    function automatic bit flow_positive(int x, int y);
        longint axx, axy, ayy, bx, by, det, u, v, c0, d, gx, gy;
        int dx;
        int dy;
        axx = 0; axy = 0; ayy = 0; bx = 0; by = 0;
        if (on_border(x, y))
            return 1'b0;
        for (dy = -1; dy <= 1; dy++)
            for (dx = -1; dx <= 1; dx++)
            begin
                c0  = cur_pix[pix_addr(x + dx, y + dy)];
                d   = longint'(ref_pix[pix_addr(x + dx, y + dy)]) - c0;
                gx  = longint'(cur_pix[pix_addr(x + dx + 1, y + dy)]) - c0;
                gy  = longint'(cur_pix[pix_addr(x + dx, y + dy + 1)]) - c0;
                axx += gx * gx;
                axy += gx * gy;
                ayy += gy * gy;
                bx  += gx * d;
                by  += gy * d;
            end
        det = axx * ayy - axy * axy;
        if (det > 0)
        begin
            u = ayy * bx - axy * by;
            v = axx * by - axy * bx;
        end
        else if (axx != 0 || axy != 0 || ayy != 0)
        begin
            // rank one: pinv is a positive multiple of A
            u = axx * bx + axy * by;
            v = axy * bx + ayy * by;
        end
        else
        begin
            u = 0;
            v = 0;
        end
        return (u > 0 || v > 0);
    endfunction

    // Drive one item, wait for acceptance, update the predictor
    task automatic push_item(command_t cmd, int col, int row, int pix, int hit);
        in_item_t  it;
        out_item_t hit_pt;
        bit        moving;
        int        gap;
        it.command     = cmd;
        it.column      = col[COL_W-1:0];
        it.row         = row[ROW_W-1:0];
        it.pixel_value = pix[PIX_W-1:0];
        in_data  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        n_items++;
        moving = 1'b0;
        case (cmd)
            CMD_WRITE_REF:
            begin
                ref_pix[pix_addr(col, row)] = pix[PIX_W-1:0];
                ref_set[pix_addr(col, row)] = 1'b1;
            end
            CMD_WRITE_CUR:
            begin
                cur_pix[pix_addr(col, row)] = pix[PIX_W-1:0];
                cur_set[pix_addr(col, row)] = 1'b1;
            end
            CMD_TEST:
            begin
                n_tests++;
                moving = flow_positive(col, row);
                if (moving)
                begin
                    hit_pt.point_column = it.column;
                    hit_pt.point_row    = it.row;
                    moving_q.insert(moving_q.size(), hit_pt);
                    n_moving++;
                end
            end
            default: ;
        endcase
        if (hit >= 0 && int'(moving) != hit)
        begin
            $display("%0t: typed result count for (%0d,%0d) expected %0d actual %0d",
                     $time, col, row, hit, moving);
            errors++;
        end
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait until idle, then write both size registers
    task automatic set_frame_size(int c, int r);
        in_valid <= 1'b0;
        while (moving_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_COLUMNS;
        cfg_data  <= c[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= REG_ROWS;
        cfg_data  <= r[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        cols_reg = c;
        rows_reg = r;
    endtask

    // Rewrite the patch at the origin in both frames
    task automatic fill_region(fill_mode_t mode);
        int c;
        int r;
        int v;
        for (r = 0; r < REGION; r++)
            for (c = 0; c < REGION; c++)
            begin
                case (mode)
                    FILL_FLAT: v = 100;
                    FILL_RAMP: v = c * 16;
                    default:   v = $urandom_range(0, 255);
                endcase
                push_item(CMD_WRITE_CUR, c, r, v, -1);
                if (mode == FILL_RANDOM)
                    v = $urandom_range(0, 255);
                else
                    v = v + $urandom_range(0, 40) - 20;
                v = (v < 0) ? 0 : (v > 255) ? 255 : v;
                push_item(CMD_WRITE_REF, c, r, v, -1);
            end
    endtask

    task automatic random_items(fill_mode_t mode, int n);
        int       k;
        int       sel;
        int       x;
        int       y;
        command_t cmd;
        for (k = 0; k < n; k++)
        begin
            sel = $urandom_range(0, 99);
            cmd = (mode == FILL_RANDOM && $urandom_range(0, 1)) ? CMD_WRITE_CUR : CMD_WRITE_REF;
            if (sel < 55)
            begin
                x = $urandom_range(0, 255);
                y = $urandom_range(0, 255);
                if ($urandom_range(0, 9) < 7 || (!on_border(x, y) && !window_written(x, y)))
                begin
                    x = $urandom_range(2, REGION - 3);
                    y = $urandom_range(2, REGION - 3);
                end
                push_item(CMD_TEST, x, y, $urandom_range(0, 255), -1);
            end
            else if (sel < 90)
                push_item(cmd, $urandom_range(0, REGION - 1), $urandom_range(0, REGION - 1),
                          $urandom_range(0, 255), -1);
            else if (sel < 96)
                push_item(cmd, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), -1);
            else
                push_item(CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), -1);
        end
    endtask

    // Receiver: random stalls, one long hold-off on request
    always
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                n_taken++;
                if (moving_q.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual (%0d,%0d)",
                             $time, out_data.point_column, out_data.point_row);
                    errors++;
                end
                else
                begin
                    out_item_t want;
                    want = moving_q.pop_front();
                    if (out_data.point_column !== want.point_column)
                    begin
                        $display("%0t: point_column expected %0d actual %0d",
                                 $time, want.point_column, out_data.point_column);
                        errors++;
                    end
                    if (out_data.point_row !== want.point_row)
                    begin
                        $display("%0t: point_row expected %0d actual %0d",
                                 $time, want.point_row, out_data.point_row);
                        errors++;
                    end
                end
            end
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = draw_gap();
            end
        end
    end

    // Watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, moving_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : main
        int k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: border rejection, unused command, writes at the extremes
        for (k = 0; k < $size(dir_tab); k++)
            push_item(dir_tab[k].cmd, dir_tab[k].col, dir_tab[k].row, dir_tab[k].pix,
                      dir_tab[k].hit);

        // Random phases over several frame sizes
        fill_region(FILL_RANDOM);
        hold_req = 1'b1;
        random_items(FILL_RANDOM, 160);
        set_frame_size(5, 5);
        random_items(FILL_RANDOM, 60);
        set_frame_size(511, 511);
        steady = 1'b1;
        random_items(FILL_RANDOM, 150);
        steady = 1'b0;
        set_frame_size(REGION + 2, 9);
        random_items(FILL_RANDOM, 100);
        set_frame_size(200, 6);
        random_items(FILL_RANDOM, 60);
        set_frame_size(256, 256);
        fill_region(FILL_FLAT);
        random_items(FILL_FLAT, 60);
        fill_region(FILL_RAMP);
        random_items(FILL_RAMP, 90);
        fill_region(FILL_RANDOM);
        random_items(FILL_RANDOM, 150);

        in_valid <= 1'b0;
        while (moving_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Covered %0d items, %0d point tests, %0d moving points checked",
                 n_items, n_tests, n_taken);
        $display("Frame sizes from 5x5 to oversized, flat, ramp and random frames, errors %0d",
                 errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
